// ===== src/swtq_pkg.sv =====
// Shared types and constants for the sorted wake-up timer queue.
package swtq_pkg;

  localparam int unsigned TIME_W      = 48;
  localparam int unsigned TID_W       = 8;
  localparam int unsigned DUR_W       = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned EVT_W       = 2;
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned S_TDATA_W   = 88;  // now, thread_id, duration
  localparam int unsigned M_TDATA_W   = 56;  // woken_thread, next_deadline

  typedef logic [TIME_W-1:0] time_t;

  // Request kinds; the fourth code is unused and only reports the deadline.
  typedef enum logic [KIND_W-1:0] {
    KIND_SLEEP = 2'd0,
    KIND_SLICE = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [EVT_W-1:0] {
    EVT_WAKE     = 2'd0,
    EVT_EXPIRED  = 2'd1,
    EVT_DEADLINE = 2'd2,
    EVT_OVERFLOW = 2'd3
  } evt_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;
    logic set_slice;
    logic clr_slice;
    logic ins_init;
    logic rd_en;
    logic rd_head;
    logic rd_back2;
    logic wr_shift;
    logic wr_new;
    logic pop;
    logic emit;
    evt_e emit_evt;
    logic emit_last;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              count_zero;
    logic              full;
    logic              idx_zero;
    logic              idx_one;
    logic              ins_shift;
    logic              pop_ok;
    logic              slice_expired;
    logic              out_free;
  } dp_sts_t;

endpackage

// ===== src/sorted_wakeup_timer_queue.sv =====
// Top level of the sorted wake-up timer queue: controller plus datapath.
//
//   channel  | direction | tuser       | tdata (low bit up)                    | tlast
//   s_axis   | in        | kind[1:0]   | now[47:0], thread_id[55:48],          | -
//            |           |             | duration[87:56]                       |
//   m_axis   | out       | event_res   | woken_thread[7:0], next_deadline[55:8]| last
//
// One request at a time. A request is taken while idle and then dispatched by kind.
// A sleep request walks from the tail toward its slot, one compare and shift per
// entry that it passes, bounded by the single RAM read port.
// A tick reads the head, then compares and pops, once for each woken entry.
// Each result leaves through one output register, the closing one carrying the
// next deadline; a stalled m_axis holds the controller in place.
// Reset empties the queue and clears the timeslice; the entry RAM needs no clear.
module sorted_wakeup_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = swtq_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [swtq_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // now, thread_id, duration
  input  logic [swtq_pkg::KIND_W-1:0]        s_axis_tuser,  // kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [swtq_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // woken_thread, next_deadline
  output logic [swtq_pkg::EVT_W-1:0]         m_axis_tuser,  // event_res
  output logic                               m_axis_tlast   // last
);
  import swtq_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [TID_W-1:0]  woken_thread;
  time_t             next_deadline;

  // Controller: sequence insert walk, pops and result emission.
  swtq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath: unpack the request fields straight from the stream.
  swtq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .kind_i          (s_axis_tuser),
    .now_i           (s_axis_tdata[TIME_W-1:0]),
    .thread_id_i     (s_axis_tdata[TIME_W+TID_W-1:TIME_W]),
    .duration_i      (s_axis_tdata[TIME_W+TID_W+DUR_W-1:TIME_W+TID_W]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .event_res_o     (m_axis_tuser),
    .woken_thread_o  (woken_thread),
    .next_deadline_o (next_deadline),
    .last_o          (m_axis_tlast)
  );

  // Pack the result payload, thread id in the low byte.
  assign m_axis_tdata = {next_deadline, woken_thread};

endmodule

// ===== src/swtq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/swtq_ctrl.sv =====
// Controller state machine for the sorted wake-up timer queue.
module swtq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  swtq_pkg::dp_sts_t sts_i,
  output swtq_pkg::dp_cmd_t cmd_o
);
  import swtq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_INS_CHK, ST_INS_CMP, ST_OVF, ST_EXPIRE,
    ST_POP_RD, ST_POP_CMP, ST_NEXT_RD, ST_NEXT_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.emit_evt = EVT_DEADLINE;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.kind)
          KIND_SLEEP: begin
            if (sts_i.full) begin
              state_d = ST_OVF;
            end else begin
              cmd_o.ins_init = 1'b1;
              state_d = ST_INS_CHK;
            end
          end
          KIND_SLICE: begin
            cmd_o.set_slice = 1'b1;
            state_d = ST_NEXT_RD;
          end
          KIND_TICK: begin
            state_d = sts_i.slice_expired ? ST_EXPIRE : ST_POP_RD;
          end
          default: state_d = ST_NEXT_RD;
        endcase
      end
      ST_INS_CHK: begin
        if (sts_i.idx_zero) begin
          cmd_o.wr_new = 1'b1;
          state_d = ST_NEXT_RD;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.ins_shift) begin
          cmd_o.wr_shift = 1'b1;
          if (sts_i.idx_one) begin
            state_d = ST_INS_CHK;
          end else begin
            cmd_o.rd_en    = 1'b1;
            cmd_o.rd_back2 = 1'b1;
          end
        end else begin
          cmd_o.wr_new = 1'b1;
          state_d = ST_NEXT_RD;
        end
      end
      ST_OVF: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_evt = EVT_OVERFLOW;
          state_d = ST_NEXT_RD;
        end
      end
      ST_EXPIRE: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_evt  = EVT_EXPIRED;
          cmd_o.clr_slice = 1'b1;
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        if (sts_i.count_zero) begin
          state_d = ST_NEXT_EMIT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_head = 1'b1;
          state_d = ST_POP_CMP;
        end
      end
      ST_POP_CMP: begin
        if (!sts_i.pop_ok) begin
          state_d = ST_NEXT_EMIT;
        end else if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_evt = EVT_WAKE;
          cmd_o.pop      = 1'b1;
          state_d = ST_POP_RD;
        end
      end
      ST_NEXT_RD: begin
        cmd_o.rd_en   = !sts_i.count_zero;
        cmd_o.rd_head = 1'b1;
        state_d = ST_NEXT_EMIT;
      end
      ST_NEXT_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_evt  = EVT_DEADLINE;
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/swtq_dp.sv =====
// Datapath: circular entry store, counters, deadline and result register.
module swtq_dp #(
  parameter int unsigned QUEUE_DEPTH = swtq_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [swtq_pkg::KIND_W-1:0]     kind_i,
  input  logic [swtq_pkg::TIME_W-1:0]     now_i,
  input  logic [swtq_pkg::TID_W-1:0]      thread_id_i,
  input  logic [swtq_pkg::DUR_W-1:0]      duration_i,
  input  swtq_pkg::dp_cmd_t               cmd_i,
  output swtq_pkg::dp_sts_t               sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [swtq_pkg::EVT_W-1:0]      event_res_o,
  output logic [swtq_pkg::TID_W-1:0]      woken_thread_o,
  output logic [swtq_pkg::TIME_W-1:0]     next_deadline_o,
  output logic                            last_o
);
  import swtq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = TIME_W + TID_W;
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  time_t             slice_q, slice_d;
  time_t             now_q, wt_q, limit_q;
  logic [TID_W-1:0]  tid_q;
  logic              dur_zero_q;
  logic [KIND_W-1:0] kind_q;

  logic              out_valid_q;
  logic [EVT_W-1:0]  out_evt_q;
  logic [TID_W-1:0]  out_tid_q;
  time_t             out_dl_q;
  logic              out_last_q;

  logic [TIME_W:0]   wt_sum;
  time_t             wt_sat, limit_sat;
  logic [CW-1:0]     rd_logical;
  logic [AW-1:0]     raddr, waddr;
  logic [EW-1:0]     wdata, rdata;
  time_t             rd_time, next_dl, head_time;
  logic [TID_W-1:0]  rd_tid, emit_tid;
  logic              out_free;

  // Logical slot to physical address, wrapping once past the end.
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] h,
                                            input logic [CW-1:0] l);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, l};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  // Saturating sums, worked out once when the request is taken.
  assign wt_sum    = {1'b0, now_i} + {{(TIME_W + 1 - DUR_W){1'b0}}, duration_i};
  assign wt_sat    = wt_sum[TIME_W] ? '1 : wt_sum[TIME_W-1:0];
  assign limit_sat = (now_i == '1) ? now_i : now_i + TIME_W'(1);

  assign rd_logical = cmd_i.rd_head  ? '0 :
                      cmd_i.rd_back2 ? idx_q - CW'(2) : idx_q - CW'(1);
  assign raddr = to_phys(head_q, rd_logical);
  assign waddr = to_phys(head_q, idx_q);
  assign wdata = cmd_i.wr_new ? {tid_q, wt_q} : rdata;

  swtq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_new | cmd_i.wr_shift),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_time = rdata[TIME_W-1:0];
  assign rd_tid  = rdata[EW-1:TIME_W];

  // Sooner of queue head and deadline; a zero head time counts as none.
  always_comb begin
    head_time = (count_q != '0) ? rd_time : '0;
    next_dl   = head_time;
    if (slice_q != '0 && (head_time == '0 || slice_q < head_time)) begin
      next_dl = slice_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (cmd_i.emit_evt)
      EVT_WAKE:     emit_tid = rd_tid;
      EVT_OVERFLOW: emit_tid = tid_q;
      default:      emit_tid = '0;
    endcase
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    slice_d = slice_q;
    if (cmd_i.ins_init) begin
      idx_d = count_q;
    end
    if (cmd_i.wr_shift) begin
      idx_d = idx_q - CW'(1);
    end
    if (cmd_i.wr_new) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
      head_d  = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
    end
    if (cmd_i.set_slice) begin
      slice_d = dur_zero_q ? '0 : wt_q;
    end
    if (cmd_i.clr_slice) begin
      slice_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      slice_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      slice_q <= slice_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q     <= kind_i;
      now_q      <= now_i;
      tid_q      <= thread_id_i;
      wt_q       <= wt_sat;
      limit_q    <= limit_sat;
      dur_zero_q <= (duration_i == '0);
    end
    if (cmd_i.emit) begin
      out_evt_q  <= cmd_i.emit_evt;
      out_tid_q  <= emit_tid;
      out_dl_q   <= (cmd_i.emit_evt == EVT_DEADLINE) ? next_dl : '0;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign sts_o.kind          = kind_q;
  assign sts_o.count_zero    = (count_q == '0);
  assign sts_o.full          = (count_q == CW'(QUEUE_DEPTH));
  assign sts_o.idx_zero      = (idx_q == '0);
  assign sts_o.idx_one       = (idx_q == CW'(1));
  assign sts_o.ins_shift     = (rd_time >= wt_q);
  assign sts_o.pop_ok        = (rd_time <= limit_q);
  assign sts_o.slice_expired = (slice_q != '0) && (now_q > slice_q);
  assign sts_o.out_free      = out_free;

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = out_evt_q;
  assign woken_thread_o  = out_tid_q;
  assign next_deadline_o = out_dl_q;
  assign last_o          = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |=> count_q != '0 && $past(count_q) < CW'(QUEUE_DEPTH))
    else $error("insert into a full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0 && rd_time <= limit_q)
    else $error("pop of an empty queue or an entry not yet due");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result register overwritten before it was taken");

endmodule
